// ===== hw/rtl/dapd_pkg.sv =====
package dapd_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned GainW   = 8;
  localparam int unsigned ErrW    = CountW + 1;
  localparam int unsigned LastW   = 18;
  localparam int unsigned DerW    = 18;
  localparam int unsigned SumW    = 32;
  localparam int unsigned PropW   = GainW + 1 + ErrW;
  localparam int unsigned IntW    = GainW + 1 + SumW;
  localparam int unsigned DrvW    = GainW + 1 + DerW;
  localparam int unsigned PidW    = IntW + 2;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  localparam logic [GainW-1:0]  GainPReset    = 8'd2;
  localparam logic [GainW-1:0]  GainIReset    = 8'd0;
  localparam logic [GainW-1:0]  GainDReset    = 8'd0;
  localparam logic [CountW-1:0] PwmPeriodReset = 16'd10000;
  localparam logic [CountW-1:0] DeadBandReset  = 16'd500;

  localparam logic signed [SumW-1:0] SumMax = 32'sh7FFF_FFFF;
  localparam logic signed [SumW-1:0] SumMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_BRAKE   = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_GAIN_P_X   = 3'd0,
    REG_GAIN_I_X   = 3'd1,
    REG_GAIN_D_X   = 3'd2,
    REG_GAIN_P_Y   = 3'd3,
    REG_GAIN_I_Y   = 3'd4,
    REG_GAIN_D_Y   = 3'd5,
    REG_PWM_PERIOD = 3'd6,
    REG_DEAD_BAND  = 3'd7
  } reg_idx_e;

  // load enables of the three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

// ===== hw/rtl/dapd_in_if.sv =====
interface dapd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] target_x;
  logic [15:0] target_y;
  logic [15:0] count_x;
  logic [15:0] count_y;

  modport source (output valid, output target_x, output target_y,
                  output count_x, output count_y, input ready);
  modport sink   (input valid, input target_x, input target_y,
                  input count_x, input count_y, output ready);
endinterface

// ===== hw/rtl/dapd_out_if.sv =====
interface dapd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duty_x;
  logic [1:0]  mode_x;
  logic [15:0] duty_y;
  logic [1:0]  mode_y;

  modport source (output valid, output duty_x, output mode_x,
                  output duty_y, output mode_y, input ready);
  modport sink   (input valid, input duty_x, input mode_x,
                  input duty_y, input mode_y, output ready);
endinterface

// ===== hw/rtl/dapd_axis.sv =====
module dapd_axis (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dapd_pkg::stage_en_t                 en_i,
  input  logic [dapd_pkg::CountW-1:0]         target_i,
  input  logic [dapd_pkg::CountW-1:0]         count_i,
  input  logic [dapd_pkg::GainW-1:0]          gain_p_i,
  input  logic [dapd_pkg::GainW-1:0]          gain_i_i,
  input  logic [dapd_pkg::GainW-1:0]          gain_d_i,
  input  logic [dapd_pkg::CountW-1:0]         pwm_period_i,
  input  logic [dapd_pkg::CountW-1:0]         dead_band_i,
  output logic [dapd_pkg::CountW-1:0]         duty_o,
  output dapd_pkg::mode_e                     mode_o
);
  import dapd_pkg::*;

  // controller state, updated as the item is accepted
  logic signed [LastW-1:0] last_err_q, last_err_d;
  logic signed [SumW-1:0]  err_sum_q, err_sum_d;

  logic signed [ErrW-1:0]  err;
  logic [ErrW-1:0]         neg_err;
  logic signed [SumW:0]    sum_wide;
  logic signed [DerW-1:0]  der;
  mode_e                   mode1_d;

  // stage 1
  logic signed [ErrW-1:0]  err1_q;
  logic signed [SumW-1:0]  sum1_q;
  logic signed [DerW-1:0]  der1_q;
  mode_e                   mode1_q;

  // stage 2
  logic signed [PropW-1:0] prop2_q, prop2_d;
  logic signed [IntW-1:0]  int2_q, int2_d;
  logic signed [DrvW-1:0]  drv2_q, drv2_d;
  mode_e                   mode2_q;

  // stage 3
  logic signed [PidW-1:0]  pid;
  logic [PidW-1:0]         mag;
  logic [CountW-1:0]       duty3_q, duty3_d;
  mode_e                   mode3_q;

  always_comb begin
    err      = signed'({1'b0, target_i}) - signed'({1'b0, count_i});
    neg_err  = ErrW'(-err);
    sum_wide = {err_sum_q[SumW-1], err_sum_q} + (SumW+1)'(err);
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      err_sum_d = sum_wide[SumW] ? SumMin : SumMax;
    end else begin
      err_sum_d = sum_wide[SumW-1:0];
    end
    last_err_d = LastW'(err);
    der        = DerW'(LastW'(err) - last_err_q);

    if (!err[ErrW-1] && (err != '0)) begin
      mode1_d = MODE_FORWARD;
    end else if (neg_err <= {1'b0, dead_band_i}) begin
      mode1_d = MODE_BRAKE;
    end else begin
      mode1_d = MODE_REVERSE;
    end
  end

  always_comb begin
    prop2_d = signed'({1'b0, gain_p_i}) * err1_q;
    int2_d  = signed'({1'b0, gain_i_i}) * sum1_q;
    drv2_d  = signed'({1'b0, gain_d_i}) * der1_q;
  end

  always_comb begin
    pid = PidW'(prop2_q) + PidW'(int2_q) + PidW'(drv2_q);
    mag = pid[PidW-1] ? PidW'(-pid) : PidW'(pid);
    if (mode2_q == MODE_BRAKE) begin
      duty3_d = '0;
    end else if (mag > PidW'(pwm_period_i)) begin
      duty3_d = pwm_period_i;
    end else begin
      duty3_d = mag[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      err_sum_q  <= '0;
    end else if (en_i.s1) begin
      last_err_q <= last_err_d;
      err_sum_q  <= err_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      err1_q  <= err;
      sum1_q  <= err_sum_d;
      der1_q  <= der;
      mode1_q <= mode1_d;
    end
    if (en_i.s2) begin
      prop2_q <= prop2_d;
      int2_q  <= int2_d;
      drv2_q  <= drv2_d;
      mode2_q <= mode1_q;
    end
    if (en_i.s3) begin
      duty3_q <= duty3_d;
      mode3_q <= mode2_q;
    end
  end

  assign duty_o = duty3_q;
  assign mode_o = mode3_q;

endmodule

// ===== hw/rtl/dual_axis_pid_position_drive_top.sv =====
// Two-axis PID position drive. Each input item carries a setpoint and an
// encoder count for x and y; each produces one result item with a PWM duty
// (limited to pwm_period) and a bridge mode per axis. The block takes one
// item per clock cycle unless the full pipeline is stalled at its output,
// through a 3-stage pipeline: error, integral and derivative (integral and
// last error are updated as the item is accepted), then the three gain
// multiplies, then the sum, magnitude and period limit into the output
// register. A stalled output holds back the input only once all three
// stages are full. Gains, period and dead band are APB registers at byte
// addresses 0x00..0x1C and should be written only while no item is in flight.
module dual_axis_pid_position_drive_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  dapd_in_if.sink                            in_i,
  dapd_out_if.source                         out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dapd_pkg::ApbAddrW-1:0]      paddr,
  input  logic [dapd_pkg::ApbDataW-1:0]      pwdata,
  output logic [dapd_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);
  import dapd_pkg::*;

  logic [GainW-1:0]  gain_p_x_q, gain_i_x_q, gain_d_x_q;
  logic [GainW-1:0]  gain_p_y_q, gain_i_y_q, gain_d_y_q;
  logic [CountW-1:0] pwm_period_q, dead_band_q;

  logic      cfg_wr;
  reg_idx_e  cfg_idx;

  logic      v1_q, v2_q, v3_q;
  logic      rdy1, rdy2, rdy3;
  stage_en_t en;
  mode_e     mode_x, mode_y;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_x_q   <= GainPReset;
      gain_i_x_q   <= GainIReset;
      gain_d_x_q   <= GainDReset;
      gain_p_y_q   <= GainPReset;
      gain_i_y_q   <= GainIReset;
      gain_d_y_q   <= GainDReset;
      pwm_period_q <= PwmPeriodReset;
      dead_band_q  <= DeadBandReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_GAIN_P_X:   gain_p_x_q   <= pwdata[GainW-1:0];
        REG_GAIN_I_X:   gain_i_x_q   <= pwdata[GainW-1:0];
        REG_GAIN_D_X:   gain_d_x_q   <= pwdata[GainW-1:0];
        REG_GAIN_P_Y:   gain_p_y_q   <= pwdata[GainW-1:0];
        REG_GAIN_I_Y:   gain_i_y_q   <= pwdata[GainW-1:0];
        REG_GAIN_D_Y:   gain_d_y_q   <= pwdata[GainW-1:0];
        REG_PWM_PERIOD: pwm_period_q <= pwdata[CountW-1:0];
        REG_DEAD_BAND:  dead_band_q  <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GAIN_P_X:   prdata = ApbDataW'(gain_p_x_q);
      REG_GAIN_I_X:   prdata = ApbDataW'(gain_i_x_q);
      REG_GAIN_D_X:   prdata = ApbDataW'(gain_d_x_q);
      REG_GAIN_P_Y:   prdata = ApbDataW'(gain_p_y_q);
      REG_GAIN_I_Y:   prdata = ApbDataW'(gain_i_y_q);
      REG_GAIN_D_Y:   prdata = ApbDataW'(gain_d_y_q);
      REG_PWM_PERIOD: prdata = ApbDataW'(pwm_period_q);
      REG_DEAD_BAND:  prdata = ApbDataW'(dead_band_q);
      default:        prdata = '0;
    endcase
  end

  // a stage loads when it is empty or its item moves on
  assign rdy3 = !v3_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_i.ready = rdy1;
  assign en.s1      = in_i.valid && rdy1;
  assign en.s2      = v1_q && rdy2;
  assign en.s3      = v2_q && rdy3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_i.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  dapd_axis u_axis_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .target_i     (in_i.target_x),
    .count_i      (in_i.count_x),
    .gain_p_i     (gain_p_x_q),
    .gain_i_i     (gain_i_x_q),
    .gain_d_i     (gain_d_x_q),
    .pwm_period_i (pwm_period_q),
    .dead_band_i  (dead_band_q),
    .duty_o       (out_o.duty_x),
    .mode_o       (mode_x)
  );

  dapd_axis u_axis_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .target_i     (in_i.target_y),
    .count_i      (in_i.count_y),
    .gain_p_i     (gain_p_y_q),
    .gain_i_i     (gain_i_y_q),
    .gain_d_i     (gain_d_y_q),
    .pwm_period_i (pwm_period_q),
    .dead_band_i  (dead_band_q),
    .duty_o       (out_o.duty_y),
    .mode_o       (mode_y)
  );

  assign out_o.valid  = v3_q;
  assign out_o.mode_x = mode_x;
  assign out_o.mode_y = mode_y;

  a_brake_x_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (mode_x == MODE_BRAKE)) |-> (out_o.duty_x == '0))
    else $error("x axis brakes with nonzero duty");

  a_duty_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.duty_x <= pwm_period_q) && (out_o.duty_y <= pwm_period_q)))
    else $error("duty above pwm period");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && !out_o.ready) |-> !in_i.ready)
    else $error("item taken while pipeline is full and stalled");

  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item missing from first stage");

endmodule

// ===== bench/dual_axis_pid_position_drive_top_tb.sv =====
`timescale 1ns / 1ps

module dual_axis_pid_position_drive_top_tb;
  import dapd_pkg::*;

  typedef struct packed {
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [15:0] count_x;
    logic [15:0] count_y;
  } tick_t;

  typedef struct packed {
    logic [15:0] duty;
    mode_e       mode;
  } axis_res_t;

  typedef struct packed {
    logic [15:0] duty_x;
    mode_e       mode_x;
    logic [15:0] duty_y;
    mode_e       mode_y;
  } drive_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  logic  src_valid = 1'b0;
  tick_t src_tick = '0;
  logic  snk_ready = 1'b0;
  logic  hold_off = 1'b0;

  dapd_in_if  tick_bus ();
  dapd_out_if drive_bus ();

  assign tick_bus.valid    = src_valid;
  assign tick_bus.target_x = src_tick.target_x;
  assign tick_bus.target_y = src_tick.target_y;
  assign tick_bus.count_x  = src_tick.count_x;
  assign tick_bus.count_y  = src_tick.count_y;
  assign drive_bus.ready   = snk_ready;

  dual_axis_pid_position_drive_top uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_bus),
    .out_o   (drive_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // controller state and register copy, index 0 is x, 1 is y
  logic        [7:0]  kp_q [2] = '{GainPReset, GainPReset};
  logic        [7:0]  ki_q [2] = '{GainIReset, GainIReset};
  logic        [7:0]  kd_q [2] = '{GainDReset, GainDReset};
  logic        [15:0] period_q = PwmPeriodReset;
  logic        [15:0] band_q = DeadBandReset;
  logic signed [17:0] last_err_q [2] = '{18'sd0, 18'sd0};
  logic signed [31:0] err_sum_q [2] = '{32'sd0, 32'sd0};

  tick_t      pending_ticks [$];
  drive_res_t expected_drives [$];

  int  mismatches = 0;
  bit  idling_on = 1'b1;
  bit  hold_go = 1'b0;
  bit  offering = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  stalled;
  tick_t      cur_tick;
  axis_res_t  res_x;
  axis_res_t  res_y;
  drive_res_t want;

  function automatic axis_res_t predict_axis(int ax, logic [15:0] tgt, logic [15:0] cnt);
    longint    err;
    longint    acc;
    longint    der;
    longint    pid;
    longint    mag;
    axis_res_t res;
    err = longint'(tgt) - longint'(cnt);
    acc = longint'(err_sum_q[ax]) + err;
    if (acc > longint'(SumMax)) acc = longint'(SumMax);
    if (acc < longint'(SumMin)) acc = longint'(SumMin);
    err_sum_q[ax] = acc[31:0];
    der = err - longint'(last_err_q[ax]);
    last_err_q[ax] = err[17:0];
    pid = longint'(kp_q[ax]) * err + longint'(ki_q[ax]) * acc + longint'(kd_q[ax]) * der;
    mag = (pid < 0) ? -pid : pid;
    if (mag > longint'(period_q)) mag = longint'(period_q);
    if (err > 0) begin
      res.mode = MODE_FORWARD;
      res.duty = mag[15:0];
    end else if (-err <= longint'(band_q)) begin
      res.mode = MODE_BRAKE;
      res.duty = '0;
    end else begin
      res.mode = MODE_REVERSE;
      res.duty = mag[15:0];
    end
    return res;
  endfunction

  // one axis worth of random stimulus: full range, extremes, small errors,
  // and errors right at the edge of the brake window
  function automatic void gen_axis(output logic [15:0] tgt, output logic [15:0] cnt);
    int shape;
    int err;
    int lo;
    int hi;
    int t;
    shape = $urandom_range(0, 9);
    if (shape < 3) begin
      tgt = 16'($urandom);
      cnt = 16'($urandom);
    end else if (shape < 5) begin
      tgt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      if (shape < 8) err = int'($urandom_range(0, 1200)) - 600;
      else err = -int'(band_q) + int'($urandom_range(0, 4)) - 2;
      if (err < -65535) err = -65535;
      lo = (err > 0) ? err : 0;
      hi = (err < 0) ? 65535 + err : 65535;
      t = int'($urandom_range(hi, lo));
      tgt = 16'(t);
      cnt = 16'(t - err);
    end
  endfunction

  task automatic push_tick(input logic [15:0] tx, input logic [15:0] cx,
                           input logic [15:0] ty, input logic [15:0] cy);
    tick_t tk;
    tk.target_x = tx;
    tk.count_x  = cx;
    tk.target_y = ty;
    tk.count_y  = cy;
    pending_ticks.push_back(tk);
  endtask

  task automatic settle_pipeline();
    while (pending_ticks.size() != 0 || offering || expected_drives.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // writes all eight registers, with junk above each field's width
  task automatic set_config(input logic [7:0] px, input logic [7:0] ix, input logic [7:0] dx,
                            input logic [7:0] py, input logic [7:0] iy, input logic [7:0] dy,
                            input logic [15:0] period, input logic [15:0] band);
    logic [31:0] vals [8];
    int i;
    vals[REG_GAIN_P_X]   = {24'($urandom), px};
    vals[REG_GAIN_I_X]   = {24'($urandom), ix};
    vals[REG_GAIN_D_X]   = {24'($urandom), dx};
    vals[REG_GAIN_P_Y]   = {24'($urandom), py};
    vals[REG_GAIN_I_Y]   = {24'($urandom), iy};
    vals[REG_GAIN_D_Y]   = {24'($urandom), dy};
    vals[REG_PWM_PERIOD] = {16'($urandom), period};
    vals[REG_DEAD_BAND]  = {16'($urandom), band};
    for (i = 0; i < 8; i++) begin
      @(posedge clk_i);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_e'(i), 2'b00};
      pwdata  <= vals[i];
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
    kp_q[0] = px;
    ki_q[0] = ix;
    kd_q[0] = dx;
    kp_q[1] = py;
    ki_q[1] = iy;
    kd_q[1] = dy;
    period_q = period;
    band_q = band;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offering = 1'b0;
      gap_left = 0;
      src_valid <= 1'b0;
    end else begin
      if (src_valid && tick_bus.ready) begin
        res_x = predict_axis(0, cur_tick.target_x, cur_tick.count_x);
        res_y = predict_axis(1, cur_tick.target_y, cur_tick.count_y);
        expected_drives.push_back(drive_res_t'{res_x.duty, res_x.mode, res_y.duty, res_y.mode});
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left == 0 && idling_on && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 11);
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          offering = 1'b1;
          src_tick <= cur_tick;
        end
      end
      src_valid <= offering;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left = 0;
      snk_ready <= 1'b0;
    end else begin
      if (snk_ready && drive_bus.valid) begin
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: duty_x=%0d mode_x=%0d duty_y=%0d mode_y=%0d",
                     drive_bus.duty_x, drive_bus.mode_x, drive_bus.duty_y, drive_bus.mode_y);
        end else begin
          want = expected_drives.pop_front();
          if (drive_bus.duty_x !== want.duty_x || drive_bus.mode_x !== want.mode_x ||
              drive_bus.duty_y !== want.duty_y || drive_bus.mode_y !== want.mode_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected duty_x=%0d mode_x=%0d duty_y=%0d mode_y=%0d, %s",
                       want.duty_x, want.mode_x, want.duty_y, want.mode_y,
                       $sformatf("got duty_x=%0d mode_x=%0d duty_y=%0d mode_y=%0d",
                                 drive_bus.duty_x, drive_bus.mode_x,
                                 drive_bus.duty_y, drive_bus.mode_y));
          end
        end
      end
      if (stall_left == 0 && idling_on && $urandom_range(0, 6) == 0)
        stall_left = $urandom_range(1, 11);
      stalled = (stall_left > 0);
      if (stalled) stall_left--;
      snk_ready <= !hold_off && !stalled;
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #9_600_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int ph;
    int k;
    logic [15:0] tx;
    logic [15:0] cx;
    logic [15:0] ty;
    logic [15:0] cy;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset gains: zero error, full-scale errors, both brake window edges
    push_tick(16'd0, 16'd0, 16'd65535, 16'd0);
    push_tick(16'd65535, 16'd0, 16'd0, 16'd65535);
    push_tick(16'd0, 16'd65535, 16'd65535, 16'd65535);
    push_tick(16'd1000, 16'd1500, 16'd1000, 16'd1501);
    push_tick(16'd1000, 16'd1501, 16'd1000, 16'd1500);
    push_tick(16'd1, 16'd0, 16'd0, 16'd1);
    push_tick(16'd0, 16'd1, 16'd1, 16'd0);
    push_tick(16'd65535, 16'd65535, 16'd0, 16'd0);
    settle_pipeline();

    // derivative pulls the sum negative while x still drives forward
    set_config(8'd0, 8'd0, 8'd1, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'd0);
    push_tick(16'd60000, 16'd0, 16'd65535, 16'd0);
    push_tick(16'd1, 16'd0, 16'd0, 16'd65535);
    push_tick(16'd0, 16'd0, 16'd0, 16'd1);
    push_tick(16'd0, 16'd1, 16'd40000, 16'd39999);
    push_tick(16'd30000, 16'd65535, 16'd0, 16'd0);
    push_tick(16'd65535, 16'd0, 16'd65535, 16'd65535);
    settle_pipeline();

    // zero period clamps every duty, then the smallest legal period
    set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'd0, 16'hFFFF);
    push_tick(16'd50000, 16'd10, 16'd0, 16'd65535);
    push_tick(16'd0, 16'd65535, 16'd700, 16'd0);
    settle_pipeline();
    set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'd1, 16'd0);
    push_tick(16'd50000, 16'd10, 16'd0, 16'd65535);
    push_tick(16'd0, 16'd2, 16'd3, 16'd0);
    settle_pipeline();

    // integral run: push both sums far out, bring them back by the same
    // amount and walk them across zero through the unclamped duty range
    idling_on = 1'b0;
    set_config(8'd0, 8'd1, 8'd0, 8'd0, 8'd1, 8'd0, 16'hFFFF, 16'd0);
    for (k = 0; k < 12; k++) push_tick(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
    for (k = 0; k < 12; k++) push_tick(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    for (k = 0; k < 40; k++) push_tick(16'd0, 16'd1000, 16'd1000, 16'd0);
    settle_pipeline();
    idling_on = 1'b1;

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        1: set_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
        2: set_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 16'd0);
        default: begin
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 300))
                                                 : 16'($urandom_range(1, 65535)),
                     ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 1000))
                                                 : 16'($urandom));
        end
      endcase
      if (ph == 7) idling_on = 1'b0;
      for (k = 0; k < 210; k++) begin
        gen_axis(tx, cx);
        gen_axis(ty, cy);
        push_tick(tx, cx, ty, cy);
      end
      if (ph == 3) hold_go = 1'b1;
      settle_pipeline();
    end

    repeat (12) @(posedge clk_i);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
